// ----- rtl/pps_pkg.sv -----
// Shared types, constants and table builders for the Phong pixel shader.
// No dependencies; every other file of the block imports this package.
package pps_pkg;

    localparam int FIELD_W        = 16;
    localparam int OUT_W          = 19;
    localparam int CFG_IDX_W      = 3;
    localparam int FRAC_BITS      = 14;
    localparam int LOG_TABLE_BITS = 8;
    localparam int LOG_FRAC       = 16;
    localparam int TAB_SIZE       = 1 << LOG_TABLE_BITS;
    localparam int EXP_W          = 31;
    localparam int POW_W          = 41;
    localparam longint unsigned LN2_Q30 = 64'd744261118;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE_RED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE_GREEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE_BLUE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPECULAR_RED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPECULAR_GREEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPECULAR_BLUE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SHININESS      = 3'd6;

    localparam logic [FIELD_W-1:0] COLOR_RESET = 16'd16384;
    localparam logic [FIELD_W-1:0] SHIN_RESET  = 16'd256;

    typedef logic [LOG_FRAC-1:0] log_tab_t [TAB_SIZE];
    typedef logic [EXP_W-1:0]    exp_tab_t [TAB_SIZE];

    // Fraction of log2(1.i) by repeated squaring, truncated Q0.16
    function automatic log_tab_t build_log_tab();
        log_tab_t    t;
        logic [63:0] m;
        logic [15:0] lg;
        for (int i = 0; i < TAB_SIZE; i++) begin
            m  = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
            lg = '0;
            for (int k = 0; k < LOG_FRAC; k++) begin
                m  = (m * m) >> 30;
                lg = lg << 1;
                if (m >= (64'd1 << 31)) begin
                    lg[0] = 1'b1;
                    m     = m >> 1;
                end
            end
            t[i] = lg;
        end
        return t;
    endfunction

    // 2^(i/TAB_SIZE) by a 13-term series, Q1.30
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t    t;
        logic [63:0] y;
        logic [63:0] sum;
        logic [63:0] term;
        for (int i = 0; i < TAB_SIZE; i++) begin
            y    = ((64'(i) << (30 - LOG_TABLE_BITS)) * LN2_Q30) >> 30;
            sum  = 64'd1 << 30;
            term = 64'd1 << 30;
            for (int k = 1; k <= 12; k++) begin
                term = ((term * y) >> 30) / 64'(k);
                sum  = sum + term;
            end
            t[i] = EXP_W'(sum);
        end
        return t;
    endfunction

endpackage

// ----- rtl/pps_pix_in_if.sv -----
// Input channel of the shader: view, light and normal vectors per beat.
// Depends on pps_pkg for field widths.
interface pps_pix_in_if;
    import pps_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] view_x;
    logic signed [FIELD_W-1:0] view_y;
    logic signed [FIELD_W-1:0] view_z;
    logic signed [FIELD_W-1:0] light_x;
    logic signed [FIELD_W-1:0] light_y;
    logic signed [FIELD_W-1:0] light_z;
    logic signed [FIELD_W-1:0] normal_x;
    logic signed [FIELD_W-1:0] normal_y;
    logic signed [FIELD_W-1:0] normal_z;

    modport source (output valid, view_x, view_y, view_z, light_x, light_y, light_z,
                    normal_x, normal_y, normal_z, input ready);
    modport sink   (input valid, view_x, view_y, view_z, light_x, light_y, light_z,
                    normal_x, normal_y, normal_z, output ready);
endinterface

// ----- rtl/pps_pix_out_if.sv -----
// Output channel of the shader: one shaded color per beat.
// Depends on pps_pkg for field widths.
interface pps_pix_out_if;
    import pps_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] red;
    logic signed [OUT_W-1:0] green;
    logic signed [OUT_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

// ----- rtl/pps_cfg_if.sv -----
// Configuration write channel: register index and data per beat.
// Depends on pps_pkg for widths.
interface pps_cfg_if;
    import pps_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [FIELD_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/phong_pixel_shade.sv -----
// Phong pixel shader, fifteen-stage pipeline.
//
// Channels: pix_in carries one pixel per beat (view, light and normal
// vectors, signed Q2.14); pix_out returns red, green and blue as signed
// Q5.14, saturated. cfg writes the diffuse and specular colors and the
// Q8.8 shininess; write it only while no pixel is in flight.
// Throughput: one pixel per clock while the output beat is not stalled,
// set by the pipeline having one register stage for each multiply, the
// leading-one search and each table lookup.
// Reset clears every valid bit and loads the colors with 1.0 and the
// shininess with 1.0; cfg is always ready.
// Stall: the whole pipeline holds while the output beat waits; pix_in.ready
// is low only then, so the block keeps taking pixels while the last stage
// is empty or being drained.
// Depends on pps_pkg and the interfaces pps_pix_in_if, pps_pix_out_if, pps_cfg_if.
module phong_pixel_shade (
    input  logic          clk,
    input  logic          rst_n,
    pps_pix_in_if.sink    pix_in,
    pps_pix_out_if.source pix_out,
    pps_cfg_if.sink       cfg
);
    import pps_pkg::*;

    localparam int NSTG = 15;
    localparam log_tab_t LOG_TAB = build_log_tab();
    localparam exp_tab_t EXP_TAB = build_exp_tab();
    localparam logic [POW_W-1:0] POW_ONE = POW_W'(1) << FRAC_BITS;
    localparam logic [POW_W-1:0] POW_CAP = POW_W'(1) << 40;
    localparam logic signed [45:0] OUT_MAX = 46'sd262143;
    localparam logic signed [45:0] OUT_MIN = -46'sd262144;

    // Configuration registers
    logic [FIELD_W-1:0] diffuse_reg [3];
    logic [FIELD_W-1:0] specular_reg [3];
    logic [FIELD_W-1:0] shininess_reg;

    logic            adv;
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;

    logic signed [15:0] v1_reg [3], l1_reg [3], n1_reg [3];
    logic signed [31:0] lnp1_reg [3];
    logic signed [15:0] v2_reg [3], l2_reg [3], n2_reg [3];
    logic signed [33:0] ln2_reg;
    logic signed [15:0] v3_reg [3], l3_reg [3];
    logic signed [33:0] ln3_reg;
    logic signed [49:0] q3_reg [3];
    logic signed [15:0] v4_reg [3];
    logic signed [33:0] ln4_reg;
    logic signed [23:0] r4_reg [3];
    logic signed [39:0] vp5_reg [3];
    logic signed [50:0] dp5_reg [3];
    logic signed [41:0] vr6_reg;
    logic signed [22:0] d6_reg [3], d7_reg [3], d8_reg [3], d9_reg [3], d10_reg [3];
    logic signed [22:0] d11_reg [3], d12_reg [3], d13_reg [3], d14_reg [3];
    logic [27:0]        x7_reg, x8_reg;
    logic [4:0]         m8_reg;
    logic               xz8_reg, xz9_reg, xz10_reg, xz11_reg;
    logic signed [21:0] lg9_reg;
    logic signed [38:0] yp10_reg;
    logic signed [15:0] sh11_reg;
    logic [EXP_W-1:0]   e11_reg;
    logic [POW_W-1:0]   pow12_reg;
    logic [36:0]        pl13_reg [3];
    logic [35:0]        ph13_reg [3];
    logic [43:0]        s14_reg [3];
    logic signed [OUT_W-1:0] out_reg [3];

    logic signed [50:0] r_wide [3];
    logic signed [27:0] rx7;
    logic [4:0]         m_lod;
    logic [27:0]        xn9;
    logic [LOG_TABLE_BITS-1:0] lidx9;
    logic signed [38:0] y11;
    logic signed [22:0] ip11;
    logic [5:0]         rs12;
    logic [62:0]        t12;
    logic [POW_W-1:0]   pow12_next;
    logic [57:0]        sum14 [3];
    logic signed [45:0] tot15 [3];
    logic signed [OUT_W-1:0] sat15 [3];

    // Configuration writes, always accepted
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                diffuse_reg[c]  <= COLOR_RESET;
                specular_reg[c] <= COLOR_RESET;
            end
            shininess_reg <= SHIN_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DIFFUSE_RED:    diffuse_reg[0]  <= cfg.data;
                REG_DIFFUSE_GREEN:  diffuse_reg[1]  <= cfg.data;
                REG_DIFFUSE_BLUE:   diffuse_reg[2]  <= cfg.data;
                REG_SPECULAR_RED:   specular_reg[0] <= cfg.data;
                REG_SPECULAR_GREEN: specular_reg[1] <= cfg.data;
                REG_SPECULAR_BLUE:  specular_reg[2] <= cfg.data;
                REG_SHININESS:      shininess_reg   <= cfg.data;
                default: ;
            endcase
        end
    end

    // Advance the whole pipe unless the output beat is stalled
    assign adv          = !vld_reg[NSTG-1] || pix_out.ready;
    assign pix_in.ready = adv;
    assign vld_next     = {vld_reg[NSTG-2:0], pix_in.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Reflected light, rounded: r = l - 2(l.n)n
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            r_wide[c] = (51'(l3_reg[c]) <<< (2 * FRAC_BITS)) - (51'(q3_reg[c]) <<< 1)
                      + (51'sd1 <<< (2 * FRAC_BITS - 1));
        end
    end

    // Round v.r and take its magnitude
    assign rx7 = 28'((vr6_reg + (42'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);

    // Find the leading one of the base
    always_comb
    begin
        m_lod = '0;
        for (int b = 0; b < 28; b++)
        begin
            if (x7_reg[b])
            begin
                m_lod = 5'(b);
            end
        end
    end

    // Normalize and pick the log table entry
    assign xn9   = x8_reg << (5'd27 - m8_reg);
    assign lidx9 = xn9[26 -: LOG_TABLE_BITS];

    // Round the scaled log and split into integer shift and fraction
    assign y11  = (yp10_reg + 39'sd128) >>> 8;
    assign ip11 = 23'(y11 >>> LOG_FRAC);

    // Raise 2 to the scaled log, with the zero and range cases
    assign rs12 = 6'(-sh11_reg);
    assign t12  = {e11_reg, 32'b0} >> rs12;

    always_comb
    begin
        if (shininess_reg == '0)
        begin
            pow12_next = POW_ONE;
        end
        else if (xz11_reg)
        begin
            pow12_next = '0;
        end
        else if (sh11_reg > 16'sd9)
        begin
            pow12_next = POW_CAP;
        end
        else if (sh11_reg >= 16'sd0)
        begin
            pow12_next = POW_W'(e11_reg) << sh11_reg[3:0];
        end
        else if (sh11_reg <= -16'sd63)
        begin
            pow12_next = '0;
        end
        else
        begin
            pow12_next = POW_W'(t12[62:32]) + POW_W'(t12[31]);
        end
    end

    // Combine the specular partial products, then add diffuse and saturate
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum14[c] = 58'(pl13_reg[c]) + (58'(ph13_reg[c]) << 21)
                     + (58'd1 << (FRAC_BITS - 1));
            tot15[c] = 46'(d14_reg[c]) + $signed(46'(s14_reg[c]));
            if (tot15[c] > OUT_MAX)
            begin
                sat15[c] = OUT_W'(OUT_MAX);
            end
            else if (tot15[c] < OUT_MIN)
            begin
                sat15[c] = OUT_W'(OUT_MIN);
            end
            else
            begin
                sat15[c] = OUT_W'(tot15[c]);
            end
        end
    end

    // Pipeline payload, advances together with the valid bits
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Stage 1: capture the beat and form l*n per axis
            v1_reg[0] <= pix_in.view_x;
            v1_reg[1] <= pix_in.view_y;
            v1_reg[2] <= pix_in.view_z;
            l1_reg[0] <= pix_in.light_x;
            l1_reg[1] <= pix_in.light_y;
            l1_reg[2] <= pix_in.light_z;
            n1_reg[0] <= pix_in.normal_x;
            n1_reg[1] <= pix_in.normal_y;
            n1_reg[2] <= pix_in.normal_z;
            lnp1_reg[0] <= 32'(pix_in.light_x) * 32'(pix_in.normal_x);
            lnp1_reg[1] <= 32'(pix_in.light_y) * 32'(pix_in.normal_y);
            lnp1_reg[2] <= 32'(pix_in.light_z) * 32'(pix_in.normal_z);
            // Stage 2: l.n
            ln2_reg <= 34'(lnp1_reg[0]) + 34'(lnp1_reg[1]) + 34'(lnp1_reg[2]);
            ln3_reg <= ln2_reg;
            ln4_reg <= ln3_reg;
            for (int c = 0; c < 3; c++)
            begin
                v2_reg[c] <= v1_reg[c];
                l2_reg[c] <= l1_reg[c];
                n2_reg[c] <= n1_reg[c];
                // Stage 3: (l.n)*n
                v3_reg[c] <= v2_reg[c];
                l3_reg[c] <= l2_reg[c];
                q3_reg[c] <= 50'(ln2_reg) * 50'(n2_reg[c]);
                // Stage 4: reflected vector
                v4_reg[c] <= v3_reg[c];
                r4_reg[c] <= 24'(r_wide[c] >>> (2 * FRAC_BITS));
                // Stage 5: v*r and diffuse*(l.n)
                vp5_reg[c] <= 40'(v4_reg[c]) * 40'(r4_reg[c]);
                dp5_reg[c] <= 51'($signed({1'b0, diffuse_reg[c]})) * 51'(ln4_reg);
                // Stage 6: round diffuse term, then carry it down the pipe
                d6_reg[c]  <= 23'((dp5_reg[c] + (51'sd1 <<< (2 * FRAC_BITS - 1)))
                                  >>> (2 * FRAC_BITS));
                d7_reg[c]  <= d6_reg[c];
                d8_reg[c]  <= d7_reg[c];
                d9_reg[c]  <= d8_reg[c];
                d10_reg[c] <= d9_reg[c];
                d11_reg[c] <= d10_reg[c];
                d12_reg[c] <= d11_reg[c];
                d13_reg[c] <= d12_reg[c];
                d14_reg[c] <= d13_reg[c];
                // Stage 13: specular color times power, two partial products
                pl13_reg[c] <= 37'(specular_reg[c]) * 37'(pow12_reg[20:0]);
                ph13_reg[c] <= 36'(specular_reg[c]) * 36'(pow12_reg[40:21]);
                // Stage 14: rounded specular term
                s14_reg[c] <= 44'(sum14[c] >> FRAC_BITS);
                // Stage 15: output color
                out_reg[c] <= sat15[c];
            end
            // Stage 6: v.r
            vr6_reg <= 42'(vp5_reg[0]) + 42'(vp5_reg[1]) + 42'(vp5_reg[2]);
            // Stage 7: base magnitude
            x7_reg <= rx7[27] ? 28'(-rx7) : 28'(rx7);
            // Stage 8: leading one
            x8_reg  <= x7_reg;
            m8_reg  <= m_lod;
            xz8_reg <= (x7_reg == '0);
            // Stage 9: log2 of the base
            lg9_reg <= ((22'($signed({1'b0, m8_reg})) - 22'(FRAC_BITS)) <<< LOG_FRAC)
                     + 22'($signed({1'b0, LOG_TAB[lidx9]}));
            xz9_reg <= xz8_reg;
            // Stage 10: scale by the exponent
            yp10_reg <= 39'(lg9_reg) * 39'($signed({1'b0, shininess_reg}));
            xz10_reg <= xz9_reg;
            // Stage 11: exp table and shift amount
            e11_reg  <= EXP_TAB[y11[LOG_FRAC-1 -: LOG_TABLE_BITS]];
            sh11_reg <= 16'(ip11) + 16'(FRAC_BITS) - 16'sd30;
            xz11_reg <= xz10_reg;
            // Stage 12: power
            pow12_reg <= pow12_next;
        end
    end

    assign pix_out.valid = vld_reg[NSTG-1];
    assign pix_out.red   = out_reg[0];
    assign pix_out.green = out_reg[1];
    assign pix_out.blue  = out_reg[2];

    // An empty output stage never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !pix_out.valid |-> pix_in.ready)
        else $error("input stalled with empty output stage");

    // An accepted beat enters the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_in.valid && pix_in.ready |=> vld_reg[0])
        else $error("accepted beat lost at stage 1");

    // A zero exponent always gives a power of one
    assert property (@(posedge clk) disable iff (!rst_n)
        adv && vld_reg[10] && shininess_reg == '0 |=> pow12_reg == POW_ONE)
        else $error("zero exponent did not give unit power");

    // A stalled output stage holds its valid bit
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> vld_reg[NSTG-1])
        else $error("stalled beat dropped");

endmodule
